@@ hw/rtl/bbc_pkg.sv @@
// shared types and constants of the box pair contact test
package bbc_pkg;

  localparam int unsigned NumAxes = 3;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned SizeW   = 31;
  localparam int unsigned BoundW  = CoordW + 2;
  localparam int unsigned OvW     = SizeW + 1;
  localparam int unsigned DepthW  = 2 * OvW - 2;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } axis_e;

  typedef struct packed {
    logic signed [CoordW-1:0] a_center_x;
    logic signed [CoordW-1:0] a_center_y;
    logic signed [CoordW-1:0] a_center_z;
    logic        [SizeW-1:0]  a_size_x;
    logic        [SizeW-1:0]  a_size_y;
    logic        [SizeW-1:0]  a_size_z;
    logic signed [CoordW-1:0] b_center_x;
    logic signed [CoordW-1:0] b_center_y;
    logic signed [CoordW-1:0] b_center_z;
    logic        [SizeW-1:0]  b_size_x;
    logic        [SizeW-1:0]  b_size_y;
    logic        [SizeW-1:0]  b_size_z;
  } box_req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic        [1:0]        normal_axis;
    logic                     normal_negative;
    logic        [DepthW-1:0] depth_squared;
  } contact_res_t;

  typedef struct packed {
    logic                     hit;
    logic                     neg;
    logic        [OvW-1:0]    ov;
    logic signed [CoordW-1:0] point;
  } lane_res_t;

endpackage

@@ hw/rtl/bbc_axis.sv @@
// one axis lane: bounds, interval overlap and overlap centre over three stages
module bbc_axis (
  input  logic                              clk_i,
  input  logic signed [bbc_pkg::CoordW-1:0] ca_i,
  input  logic signed [bbc_pkg::CoordW-1:0] cb_i,
  input  logic        [bbc_pkg::SizeW-1:0]  sa_i,
  input  logic        [bbc_pkg::SizeW-1:0]  sb_i,
  output bbc_pkg::lane_res_t                res_o
);
  import bbc_pkg::*;

  logic signed [BoundW-1:0] ca2, cb2, sa_ext, sb_ext;
  logic signed [BoundW-1:0] amin_d, amax_d, bmin_d, bmax_d;
  logic signed [BoundW-1:0] amin_q, amax_q, bmin_q, bmax_q;
  logic                     neg1_d, neg1_q;

  logic                     hit2_d, hit2_q, neg2_q;
  logic signed [BoundW-1:0] lo_d, hi_d, lo_q, hi_q;

  logic signed [BoundW-1:0] diff;
  logic signed [BoundW:0]   sum;
  lane_res_t                res_d, res_q;

  // stage 1: bounds in one extra fraction bit
  always_comb begin
    ca2    = {ca_i[CoordW-1], ca_i, 1'b0};
    cb2    = {cb_i[CoordW-1], cb_i, 1'b0};
    sa_ext = {3'b000, sa_i};
    sb_ext = {3'b000, sb_i};
    amin_d = ca2 - sa_ext;
    amax_d = ca2 + sa_ext;
    bmin_d = cb2 - sb_ext;
    bmax_d = cb2 + sb_ext;
    neg1_d = ca_i < cb_i;
  end

  always_ff @(posedge clk_i) begin
    amin_q <= amin_d;
    amax_q <= amax_d;
    bmin_q <= bmin_d;
    bmax_q <= bmax_d;
    neg1_q <= neg1_d;
  end

  // stage 2: separation test and overlap interval
  always_comb begin
    hit2_d = !((amax_q < bmin_q) || (amin_q > bmax_q));
    lo_d   = (amin_q > bmin_q) ? amin_q : bmin_q;
    hi_d   = (amax_q < bmax_q) ? amax_q : bmax_q;
  end

  always_ff @(posedge clk_i) begin
    hit2_q <= hit2_d;
    neg2_q <= neg1_q;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
  end

  // stage 3: overlap length and floored region centre
  always_comb begin
    diff      = hi_q - lo_q;
    sum       = {lo_q[BoundW-1], lo_q} + {hi_q[BoundW-1], hi_q};
    res_d.hit = hit2_q;
    res_d.neg = neg2_q;
    res_d.ov  = diff[OvW-1:0];
    res_d.point = sum[CoordW+1:2];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

@@ hw/rtl/bbc_resolve.sv @@
// least overlap axis pick, depth squaring and result register
module bbc_resolve (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  bbc_pkg::lane_res_t    lane_i [bbc_pkg::NumAxes],
  output logic                  vld_o,
  output bbc_pkg::contact_res_t res_o
);
  import bbc_pkg::*;

  // stage 4 signals
  logic                     v4_q;
  logic                     hit_d, hit_q;
  axis_e                    best_d, best_q;
  logic                     neg_d, neg_q;
  logic        [OvW-1:0]    ovb_d, ov_q;
  logic        [OvW-1:0]    ov01;
  logic signed [CoordW-1:0] px_q, py_q, pz_q;

  // stage 5 signals
  logic                     v5_q;
  logic        [2*OvW-1:0]  sq;
  contact_res_t             res_d, res_q;

  always_comb begin
    hit_d  = lane_i[0].hit && lane_i[1].hit && lane_i[2].hit;
    best_d = AxisX;
    ov01   = lane_i[0].ov;
    if (lane_i[1].ov < lane_i[0].ov) begin
      best_d = AxisY;
      ov01   = lane_i[1].ov;
    end
    if (lane_i[2].ov < ov01) begin
      best_d = AxisZ;
    end
    case (best_d)
      AxisX: begin
        neg_d = lane_i[0].neg;
        ovb_d = lane_i[0].ov;
      end
      AxisY: begin
        neg_d = lane_i[1].neg;
        ovb_d = lane_i[1].ov;
      end
      AxisZ: begin
        neg_d = lane_i[2].neg;
        ovb_d = lane_i[2].ov;
      end
      default: begin
        neg_d = 1'b0;
        ovb_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    best_q <= best_d;
    neg_q  <= neg_d;
    ov_q   <= ovb_d;
    px_q   <= lane_i[0].point;
    py_q   <= lane_i[1].point;
    pz_q   <= lane_i[2].point;
  end

  // stage 5: square the least overlap, clear fields on a miss
  always_comb begin
    sq = ov_q * ov_q;
    res_d = '0;
    if (hit_q) begin
      res_d.hit             = 1'b1;
      res_d.point_x         = px_q;
      res_d.point_y         = py_q;
      res_d.point_z         = pz_q;
      res_d.normal_axis     = best_q;
      res_d.normal_negative = neg_q;
      res_d.depth_squared   = sq[2*OvW-1:2];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= vld_i;
      v5_q <= v4_q;
    end
  end

  assign vld_o = v5_q;
  assign res_o = res_q;

  a_vld_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> $past(vld_i, 2))
    else $error("result strobe without an item two stages back");

  a_miss_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_o && !res_o.hit) |-> (res_o.depth_squared == '0 && res_o.normal_axis == AxisX
                               && !res_o.normal_negative && res_o.point_x == '0))
    else $error("miss carries nonzero fields");

endmodule

@@ hw/rtl/box_box_contact_top.sv @@
// top level of the axis-aligned box pair contact test
// A box pair is taken on every cycle that start is high; busy never rises, so a new
// item may follow in the very next cycle. Each item's result appears on res_o after the
// lane and resolve stages, marked by valid_o for exactly one cycle, in the order the items
// came in; results cannot be held back, so the receiver must take each one in that cycle.
// The pipeline has three lane stages (bounds, interval, overlap) and two
// resolve stages, the last of which holds the 32 x 32 bit multiplier for the depth square.
module box_box_contact_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  bbc_pkg::box_req_t     req_i,
  output logic                  valid_o,
  output bbc_pkg::contact_res_t res_o
);
  import bbc_pkg::*;

  logic signed [CoordW-1:0] ca [NumAxes];
  logic signed [CoordW-1:0] cb [NumAxes];
  logic        [SizeW-1:0]  sa [NumAxes];
  logic        [SizeW-1:0]  sb [NumAxes];
  lane_res_t                lane [NumAxes];
  logic        [2:0]        v_d, v_q;

  assign busy = 1'b0;

  always_comb begin
    ca[0] = req_i.a_center_x;
    ca[1] = req_i.a_center_y;
    ca[2] = req_i.a_center_z;
    cb[0] = req_i.b_center_x;
    cb[1] = req_i.b_center_y;
    cb[2] = req_i.b_center_z;
    sa[0] = req_i.a_size_x;
    sa[1] = req_i.a_size_y;
    sa[2] = req_i.a_size_z;
    sb[0] = req_i.b_size_x;
    sb[1] = req_i.b_size_y;
    sb[2] = req_i.b_size_z;
  end

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    bbc_axis u_axis (
      .clk_i (clk_i),
      .ca_i  (ca[g]),
      .cb_i  (cb[g]),
      .sa_i  (sa[g]),
      .sb_i  (sb[g]),
      .res_o (lane[g])
    );
  end

  // valid bits that travel with the lane stages
  assign v_d = {v_q[1:0], start && !busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  bbc_resolve u_resolve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v_q[2]),
    .lane_i (lane),
    .vld_o  (valid_o),
    .res_o  (res_o)
  );

  a_lane_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> $past(start, 3))
    else $error("lane valid without a taken item");

endmodule
